// ===== hdl/wss_pkg.sv =====
// Package: word stack constants, word types, request and status codes, sequencer states.
package wss_pkg;

    localparam int DEPTH  = 128;
    localparam int WORD_W = 32;
    localparam int FILL_W = 8;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_PEEK   = 2'd2;
    localparam logic [1:0] REQ_SEARCH = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [WORD_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_word;
        logic              found;
        logic [1:0]        status;
        logic [FILL_W-1:0] fill_count;
        logic              is_empty;
        logic              is_full;
    } out_word_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } ram_cmd_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

// ===== hdl/wss_ram.sv =====
// Single-port entry memory with registered read data.
module wss_ram (
    input  logic                      clk,
    input  wss_pkg::ram_cmd_t         cmd,
    output logic [wss_pkg::WORD_W-1:0] rd_data
);
    import wss_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.addr] <= cmd.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.re)
        begin
            rd_data_reg <= mem[cmd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/wss_seq.sv =====
// Request sequencer: fill count, memory access and shared compare for the search walk.
module wss_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  wss_pkg::in_word_t          req_word,
    output wss_pkg::ram_cmd_t          ram_cmd,
    input  logic [wss_pkg::WORD_W-1:0] rd_data,
    output wss_pkg::res_t              res,
    input  logic                       res_take
);
    import wss_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    in_word_t          req_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] scan_idx_reg;
    logic [WORD_W-1:0] rd_word_reg;
    logic              found_reg;
    logic [1:0]        status_reg;

    logic              empty;
    logic              full;
    logic              hit;
    logic              last;
    logic [CNT_W-1:0]  count_m1;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign count_m1 = count_reg - CNT_W'(1);
    assign hit      = (rd_data == req_reg.value);
    assign last     = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (req_reg.req_type)
                    REQ_PUSH:   state_next = S_DONE;
                    REQ_SEARCH: state_next = empty ? S_DONE : S_SCAN;
                    default:    state_next = empty ? S_DONE : S_WAIT;
                endcase
            end
            S_WAIT:
            begin
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (hit || last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall           = (state_reg != S_IDLE);
        ram_cmd.we          = 1'b0;
        ram_cmd.re          = 1'b0;
        ram_cmd.addr        = '0;
        ram_cmd.wdata       = req_reg.value;
        res.valid           = (state_reg == S_DONE);
        res.word.read_word  = rd_word_reg;
        res.word.found      = found_reg;
        res.word.status     = status_reg;
        res.word.fill_count = FILL_W'(count_reg);
        res.word.is_empty   = empty;
        res.word.is_full    = full;
        case (state_reg)
            S_EXEC:
            begin
                case (req_reg.req_type)
                    REQ_PUSH:
                    begin
                        ram_cmd.we   = !full;
                        ram_cmd.addr = count_reg[ADDR_W-1:0];
                    end
                    REQ_SEARCH:
                    begin
                        ram_cmd.re   = !empty;
                        ram_cmd.addr = '0;
                    end
                    default:
                    begin
                        ram_cmd.re   = !empty;
                        ram_cmd.addr = count_m1[ADDR_W-1:0];
                    end
                endcase
            end
            S_SCAN:
            begin
                ram_cmd.re   = 1'b1;
                ram_cmd.addr = scan_idx_reg + ADDR_W'(1);
            end
            default:
            begin
                ram_cmd.re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EXEC)
            begin
                if (req_reg.req_type == REQ_PUSH && !full)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else if (req_reg.req_type == REQ_POP && !empty)
                begin
                    count_reg <= count_m1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_reg <= req_word;
                end
            end
            S_EXEC:
            begin
                rd_word_reg  <= '0;
                found_reg    <= 1'b0;
                status_reg   <= STAT_OK;
                scan_idx_reg <= '0;
                case (req_reg.req_type)
                    REQ_PUSH:
                    begin
                        if (full)
                        begin
                            status_reg <= STAT_FULL;
                        end
                    end
                    REQ_POP:
                    begin
                        if (empty)
                        begin
                            rd_word_reg <= '1;
                            status_reg  <= STAT_EMPTY;
                        end
                    end
                    REQ_PEEK:
                    begin
                        if (empty)
                        begin
                            status_reg <= STAT_EMPTY;
                        end
                    end
                    default:
                    begin
                        found_reg <= 1'b0;
                    end
                endcase
            end
            S_WAIT:
            begin
                rd_word_reg <= rd_data;
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    found_reg <= 1'b1;
                end
                scan_idx_reg <= scan_idx_reg + ADDR_W'(1);
            end
            default:
            begin
                found_reg <= found_reg;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_cmd.we |-> (state_reg == S_EXEC && req_reg.req_type == REQ_PUSH))
        else $error("memory write outside push");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && req_reg.req_type == REQ_POP && !empty)
        |=> (count_reg == CNT_W'($past(count_reg) - CNT_W'(1))))
        else $error("pop did not drop fill count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CNT_W'(scan_idx_reg) < count_reg))
        else $error("search walked past top");

endmodule

// ===== hdl/word_stack_with_search.sv =====
// Top level: word stack with search, memory, sequencer and result register.
// Push, and pop, peek or search on an empty stack, go straight from execute to done; pop or
// peek reads the top entry through a wait state; search compares entries from the bottom
// up, at most the fill count of them, and stops at the first match.
// One request at a time: the next word is accepted only once the result has been taken.
// Reset clears the fill count, sequencer and result valid; entry contents are left as is.
module word_stack_with_search (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  wss_pkg::in_word_t  req_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output wss_pkg::out_word_t rsp_word
);
    import wss_pkg::*;

    ram_cmd_t          ram_cmd;
    logic [WORD_W-1:0] rd_data;
    res_t              res;
    logic              res_take;
    logic              rsp_valid_reg;
    out_word_t         rsp_word_reg;

    wss_ram u_ram (
        .clk     (clk),
        .cmd     (ram_cmd),
        .rd_data (rd_data)
    );

    wss_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .ram_cmd   (ram_cmd),
        .rd_data   (rd_data),
        .res       (res),
        .res_take  (res_take)
    );

    assign res_take = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res.valid)
        begin
            rsp_word_reg <= res.word;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

// ===== dv/testbench.sv =====
// Testbench: word stack with search, checked word by word against a stack predictor.
module testbench;
    import wss_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RSP_HOLD       = 200;
    localparam int END_WAIT       = 150;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    in_word_t  req_word;
    logic      rsp_valid;
    logic      rsp_stall;
    out_word_t rsp_word;

    logic [WORD_W-1:0] stack_mem [DEPTH];
    int                stack_fill = 0;
    out_word_t         predicted_words [$];
    int                error_count = 0;
    bit                quiet = 1'b0;
    bit                hold_rsp = 1'b0;
    int                stuck_cycles = 0;

    word_stack_with_search i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    always #5 clk = ~clk;

    function automatic out_word_t predict_stack(input in_word_t w);
        out_word_t r;
        r = '0;
        case (w.req_type)
            REQ_PUSH:
                if (stack_fill >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    stack_mem[ADDR_W'(stack_fill)] = w.value;
                    stack_fill++;
                end
            REQ_POP:
                if (stack_fill == 0)
                begin
                    r.read_word = '1;
                    r.status    = STAT_EMPTY;
                end
                else
                begin
                    stack_fill--;
                    r.read_word = stack_mem[ADDR_W'(stack_fill)];
                end
            REQ_PEEK:
                if (stack_fill == 0)
                    r.status = STAT_EMPTY;
                else
                    r.read_word = stack_mem[ADDR_W'(stack_fill - 1)];
            default:
                for (int i = 0; i < stack_fill; i++)
                    if (stack_mem[ADDR_W'(i)] == w.value)
                        r.found = 1'b1;
        endcase
        r.fill_count = stack_fill[FILL_W-1:0];
        r.is_empty   = (stack_fill == 0);
        r.is_full    = (stack_fill == DEPTH);
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return $urandom_range(0, 7);
        else if (r < 30)
            return '1;
        else if (r < 35)
            return '0;
        return $urandom;
    endfunction

    function automatic logic [WORD_W-1:0] held_word();
        if (stack_fill == 0)
            return rand_word();
        return stack_mem[ADDR_W'($urandom_range(0, stack_fill - 1))];
    endfunction

    task automatic send_word(input logic [1:0] kind, input logic [WORD_W-1:0] data);
        in_word_t w;
        w.req_type = kind;
        w.value    = data;
        if (!quiet)
            while ($urandom_range(0, 99) < 19)
            begin
                if (req_valid)
                    req_valid <= 1'b0;
                @(posedge clk);
            end
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted_words.push_back(predict_stack(w));
    endtask

    task automatic wait_drain();
        req_valid <= 1'b0;
        while (predicted_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random(input int n, input int push_weight);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < push_weight)
                send_word(REQ_PUSH, rand_word());
            else if (r < 80)
                send_word(REQ_POP, $urandom);
            else if (r < 90)
                send_word(REQ_PEEK, $urandom);
            else if ($urandom_range(0, 9) < 6)
                send_word(REQ_SEARCH, held_word());
            else
                send_word(REQ_SEARCH, rand_word());
        end
    endtask

    task automatic test_edge_cases();
        send_word(REQ_POP, 32'h0);
        send_word(REQ_PEEK, '1);
        send_word(REQ_SEARCH, 32'h0);
        send_word(REQ_SEARCH, '1);
        send_word(REQ_PUSH, '1);
        send_word(REQ_PUSH, 32'h0);
        send_word(REQ_PEEK, 32'h1234_5678);
        send_word(REQ_SEARCH, 32'h0);
        send_word(REQ_SEARCH, '1);
        send_word(REQ_SEARCH, 32'h1);
        send_word(REQ_POP, '1);
        send_word(REQ_PEEK, 32'h0);
        send_word(REQ_POP, 32'h0);
        send_word(REQ_POP, '1);
        send_word(REQ_PEEK, 32'h0);
        send_word(REQ_PUSH, 32'h8000_0001);
        send_word(REQ_SEARCH, 32'h8000_0001);
        send_word(REQ_SEARCH, 32'h7FFF_FFFE);
        send_word(REQ_POP, 32'h0);
        wait_drain();
    endtask

    task automatic test_fill_and_drain();
        while (stack_fill < DEPTH)
            send_word(REQ_PUSH, rand_word());
        repeat (3)
            send_word(REQ_PUSH, $urandom);
        send_word(REQ_SEARCH, stack_mem[0]);
        send_word(REQ_SEARCH, stack_mem[DEPTH - 1]);
        send_word(REQ_SEARCH, $urandom);
        send_word(REQ_PEEK, $urandom);
        while (stack_fill > 0)
        begin
            if (stack_fill % 16 == 0)
                send_word(REQ_SEARCH, held_word());
            send_word(REQ_POP, $urandom);
        end
        send_word(REQ_POP, $urandom);
        send_word(REQ_SEARCH, $urandom);
        wait_drain();
    endtask

    task automatic test_random_mix();
        send_random(200, 65);
        send_random(200, 30);
        send_random(150, 50);
        wait_drain();
    endtask

    task automatic test_backpressure();
        hold_rsp = 1'b1;
        send_random(40, 60);
        wait_drain();
    endtask

    task automatic test_no_idle();
        quiet = 1'b1;
        send_random(150, 55);
        wait_drain();
        quiet = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                               input logic [WORD_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            error_count++;
            $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin : check_rsp
        out_word_t exp_w;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (predicted_words.size() == 0)
            begin
                error_count++;
                $display("%0t unexpected word expected none actual %h", $time, rsp_word);
            end
            else
            begin
                exp_w = predicted_words.pop_front();
                check_field("read_word", exp_w.read_word, rsp_word.read_word);
                check_field("found", WORD_W'(exp_w.found), WORD_W'(rsp_word.found));
                check_field("status", WORD_W'(exp_w.status), WORD_W'(rsp_word.status));
                check_field("fill_count", WORD_W'(exp_w.fill_count),
                            WORD_W'(rsp_word.fill_count));
                check_field("is_empty", WORD_W'(exp_w.is_empty), WORD_W'(rsp_word.is_empty));
                check_field("is_full", WORD_W'(exp_w.is_full), WORD_W'(rsp_word.is_full));
            end
        end
    end

    initial
    begin : rsp_side
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                rsp_stall <= 1'b1;
                repeat (RSP_HOLD)
                    @(posedge clk);
                hold_rsp = 1'b0;
                rsp_stall <= 1'b0;
            end
            else
                rsp_stall <= !quiet && ($urandom_range(0, 99) < 19);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_word  <= '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_cases();
        test_fill_and_drain();
        test_random_mix();
        test_backpressure();
        test_no_idle();
        repeat (END_WAIT)
            @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
